FILE: hw/rtl/csc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types and constants for the set-associative cache controller.
// ----------------------------------------------------------------------------
package csc_pkg;

    localparam int SET_BITS_MAX_DEF  = 8;
    localparam int WAYS_DEF          = 8;
    localparam int MEM_WORD_COST_DEF = 100;

    localparam int TAG_W      = 30;
    localparam int STAMP_W    = 32;
    localparam int CNT_W      = 32;
    localparam int TOTAL_W    = 64;
    localparam int ACC_CYC_W  = 18;
    localparam int CFG_ADDR_W = 5;

    // register indexes on the configuration port
    localparam logic [2:0] REG_REPLACE_FIFO = 3'd0;
    localparam logic [2:0] REG_ALLOC_WRITE  = 3'd1;
    localparam logic [2:0] REG_WRITE_THRU   = 3'd2;
    localparam logic [2:0] REG_OFFSET_BITS  = 3'd3;
    localparam logic [2:0] REG_INDEX_BITS   = 3'd4;
    localparam logic [2:0] REG_WAYS_IN_USE  = 3'd5;

    // outcome codes
    localparam logic [1:0] OUT_LOAD_HIT   = 2'd0;
    localparam logic [1:0] OUT_LOAD_MISS  = 2'd1;
    localparam logic [1:0] OUT_STORE_HIT  = 2'd2;
    localparam logic [1:0] OUT_STORE_MISS = 2'd3;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic               valid;
        logic               dirty;
        logic [STAMP_W-1:0] lstamp;
        logic [STAMP_W-1:0] ustamp;
    } way_t;

    localparam int WAY_BITS = $bits(way_t);

    typedef struct packed {
        logic [1:0] outcome;
        logic       hit;
        logic       filled;
        logic       wrote_back;
    } lookup_t;

endpackage

FILE: hw/rtl/csc_tag_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_tag_ram
// One row per set holding tag, flags and stamps of every way; registered read.
// ----------------------------------------------------------------------------
module csc_tag_ram #(
    parameter int AddrW = 8,
    parameter int RowW  = 768
) (
    input  logic             aclk,
    input  logic             rd_en,
    input  logic [AddrW-1:0] rd_addr,
    output logic [RowW-1:0]  rd_data,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [RowW-1:0]  wr_data
);

    localparam int Depth = 1 << AddrW;

    logic [RowW-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hw/rtl/csc_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_lookup
// Tag search, victim choice, cost and updated row for one access.
// ----------------------------------------------------------------------------
module csc_lookup #(
    parameter int Ways        = 8,
    parameter int MemWordCost = 100,
    parameter int CycW        = 21,
    parameter int NwW         = 4
) (
    input  csc_pkg::way_t [Ways-1:0]         row,
    input  logic                             row_ok,
    input  logic [csc_pkg::TAG_W-1:0]        tag,
    input  logic                             store,
    input  logic [NwW-1:0]                   nways,
    input  logic                             fifo,
    input  logic                             alloc,
    input  logic                             wthru,
    input  logic [3:0]                       off_m2,
    input  logic [csc_pkg::STAMP_W-1:0]      clk_new,
    output csc_pkg::way_t [Ways-1:0]         new_row,
    output csc_pkg::lookup_t                 res,
    output logic [CycW-1:0]                  cyc
);

    localparam int WayW = (Ways > 1) ? $clog2(Ways) : 1;

    csc_pkg::way_t [Ways-1:0]     cur;
    logic                         hit;
    logic [WayW-1:0]              hway;
    logic                         found_inv;
    logic [WayW-1:0]              iway;
    logic [WayW-1:0]              mway;
    logic [csc_pkg::STAMP_W-1:0]  best;
    logic [csc_pkg::STAMP_W-1:0]  s;
    logic [WayW-1:0]              vway;
    logic [CycW-1:0]              fc;
    logic [CycW-1:0]              wc;
    logic                         do_fill;

    always_comb begin
        for (int w = 0; w < Ways; w++) begin
            cur[w]       = row[w];
            cur[w].valid = row[w].valid & row_ok;
            cur[w].dirty = row[w].dirty & row_ok;
        end

        hit  = 1'b0;
        hway = '0;
        found_inv = 1'b0;
        iway = '0;
        for (int w = 0; w < Ways; w++) begin
            if (w < int'(nways)) begin
                if (!hit && cur[w].valid && cur[w].tag == tag) begin
                    hit  = 1'b1;
                    hway = WayW'(w);
                end
                if (!found_inv && !cur[w].valid) begin
                    found_inv = 1'b1;
                    iway = WayW'(w);
                end
            end
        end

        // oldest stamp, ties to the lowest way
        best = fifo ? cur[0].lstamp : cur[0].ustamp;
        mway = '0;
        for (int w = 1; w < Ways; w++) begin
            s = fifo ? cur[w].lstamp : cur[w].ustamp;
            if (w < int'(nways) && s < best) begin
                best = s;
                mway = WayW'(w);
            end
        end
        vway = found_inv ? iway : mway;

        fc = CycW'(MemWordCost) << off_m2;
        wc = CycW'(MemWordCost);
        do_fill = !hit && (alloc || !store);

        new_row = cur;
        res.hit = hit;
        res.filled = do_fill;
        res.wrote_back = 1'b0;
        if (hit) begin
            res.outcome = store ? csc_pkg::OUT_STORE_HIT : csc_pkg::OUT_LOAD_HIT;
            cyc = CycW'(1) + ((store && wthru) ? wc : '0);
            new_row[hway].ustamp = clk_new;
            if (store && !wthru) begin
                new_row[hway].dirty = 1'b1;
            end
        end else if (do_fill) begin
            res.outcome = store ? csc_pkg::OUT_STORE_MISS : csc_pkg::OUT_LOAD_MISS;
            res.wrote_back = cur[vway].valid && cur[vway].dirty && !wthru;
            cyc = fc + (res.wrote_back ? fc : '0) + ((store && wthru) ? wc : '0);
            new_row[vway].tag    = tag;
            new_row[vway].valid  = 1'b1;
            new_row[vway].dirty  = store && !wthru;
            new_row[vway].lstamp = clk_new;
            new_row[vway].ustamp = clk_new;
        end else begin
            res.outcome = csc_pkg::OUT_STORE_MISS;
            cyc = wc;
        end
    end

endmodule

FILE: hw/rtl/set_assoc_cache_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_controller
// Set-associative cache model: tag lookup, replacement, cost and statistics.
// ----------------------------------------------------------------------------
// Input stream: s_tdata carries the byte address, s_tuser the access kind
// (0 load, 1 store). Output stream: one result per access with outcome,
// charged cycles, fill/writeback flags and saturating running totals.
// An access reads the set's row from the tag memory when accepted in
// ST_IDLE; in ST_RUN it compares tags, picks the victim, writes the row back
// and loads the result register. s_tready is high only in ST_IDLE, so a new
// access is not taken until the previous one commits, which waits for a free
// result register. If the receiver stalls, the finished result waits in the
// result register, one more access may be read, and its commit waits until
// the register frees. Reset clears the per-set valid flags (all ways read as
// invalid), the access clock and the counters, sets the configuration to its
// defaults and runs no clearing pass. Configuration is to be written through
// the APB port only while no access is in flight; this is not enforced.
// ----------------------------------------------------------------------------
module set_assoc_cache_controller #(
    parameter int SetBitsMax  = csc_pkg::SET_BITS_MAX_DEF,
    parameter int Ways        = csc_pkg::WAYS_DEF,
    parameter int MemWordCost = csc_pkg::MEM_WORD_COST_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // apb
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [csc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // address
    input  logic [0:0]                     s_tuser,   // opcode
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // outcome, access_cycles, block_filled, dirty_written_back, load_count,
    // store_count, load_hit_count, load_miss_count, store_hit_count,
    // store_miss_count, cycle_total, zero fill
    output logic [279:0]                   m_tdata
);

    localparam int SetW  = (SetBitsMax > 0) ? SetBitsMax : 1;
    localparam int Depth = 1 << SetW;
    localparam int NwW   = $clog2(Ways + 1);
    localparam int CycW  = $clog2(MemWordCost * 2049 + 1);
    localparam int RowW  = Ways * csc_pkg::WAY_BITS;
    localparam int CW    = csc_pkg::CNT_W;
    localparam int TW    = csc_pkg::TOTAL_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic       fifo_reg, alloc_reg, wthru_reg;
    logic [3:0] offb_reg, idxb_reg, wiu_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fifo_reg  <= 1'b0;
            alloc_reg <= 1'b1;
            wthru_reg <= 1'b0;
            offb_reg  <= 4'd4;
            idxb_reg  <= 4'd0;
            wiu_reg   <= 4'd8;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                csc_pkg::REG_REPLACE_FIFO: fifo_reg  <= pwdata[0];
                csc_pkg::REG_ALLOC_WRITE:  alloc_reg <= pwdata[0];
                csc_pkg::REG_WRITE_THRU:   wthru_reg <= pwdata[0];
                csc_pkg::REG_OFFSET_BITS:  offb_reg  <= pwdata[3:0];
                csc_pkg::REG_INDEX_BITS:   idxb_reg  <= pwdata[3:0];
                csc_pkg::REG_WAYS_IN_USE:  wiu_reg   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            csc_pkg::REG_REPLACE_FIFO: prdata = {31'd0, fifo_reg};
            csc_pkg::REG_ALLOC_WRITE:  prdata = {31'd0, alloc_reg};
            csc_pkg::REG_WRITE_THRU:   prdata = {31'd0, wthru_reg};
            csc_pkg::REG_OFFSET_BITS:  prdata = {28'd0, offb_reg};
            csc_pkg::REG_INDEX_BITS:   prdata = {28'd0, idxb_reg};
            csc_pkg::REG_WAYS_IN_USE:  prdata = {28'd0, wiu_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // geometry with out-of-range settings clamped
    logic [3:0]     off;
    logic [3:0]     idx;
    logic [NwW-1:0] nways;
    logic [31:0]    set_full;
    logic [SetW-1:0] set_in;
    logic [csc_pkg::TAG_W-1:0] tag_in;

    always_comb begin
        off = (offb_reg < 4'd2) ? 4'd2 : ((offb_reg > 4'd12) ? 4'd12 : offb_reg);
        idx = (int'(idxb_reg) > SetBitsMax) ? 4'(SetBitsMax) : idxb_reg;
        if (wiu_reg == 4'd0) begin
            nways = NwW'(1);
        end else if (int'(wiu_reg) > Ways) begin
            nways = NwW'(Ways);
        end else begin
            nways = NwW'(wiu_reg);
        end
        set_full = (s_tdata >> off) & ((32'd1 << idx) - 32'd1);
        set_in   = set_full[SetW-1:0];
        tag_in   = csc_pkg::TAG_W'(s_tdata >> ({1'b0, off} + {1'b0, idx}));
    end

    logic s_acc;
    logic commit;
    logic out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid || m_tready;
    assign commit   = (state_reg == ST_RUN) && out_free;

    logic [SetW-1:0]           set_reg;
    logic [csc_pkg::TAG_W-1:0] tag_reg;
    logic                      store_reg;

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            set_reg   <= set_in;
            tag_reg   <= tag_in;
            store_reg <= s_tuser[0];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_acc)  state_next = ST_RUN;
            ST_RUN:  if (commit) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // tag memory and per-set valid flags
    logic [RowW-1:0]                rd_row;
    csc_pkg::way_t [Ways-1:0]       cur_row;
    csc_pkg::way_t [Ways-1:0]       new_row;
    logic [Depth-1:0]               row_vld_reg;

    assign cur_row = rd_row;

    csc_tag_ram #(
        .AddrW (SetW),
        .RowW  (RowW)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (s_acc),
        .rd_addr (set_in),
        .rd_data (rd_row),
        .wr_en   (commit),
        .wr_addr (set_reg),
        .wr_data (new_row)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
        end else if (commit) begin
            row_vld_reg[set_reg] <= 1'b1;
        end
    end

    logic [csc_pkg::STAMP_W-1:0] clk_reg;
    logic [csc_pkg::STAMP_W-1:0] clk_next;
    csc_pkg::lookup_t            res;
    logic [CycW-1:0]             cyc;

    assign clk_next = clk_reg + 1'b1;

    csc_lookup #(
        .Ways        (Ways),
        .MemWordCost (MemWordCost),
        .CycW        (CycW),
        .NwW         (NwW)
    ) u_lookup (
        .row     (cur_row),
        .row_ok  (row_vld_reg[set_reg]),
        .tag     (tag_reg),
        .store   (store_reg),
        .nways   (nways),
        .fifo    (fifo_reg),
        .alloc   (alloc_reg),
        .wthru   (wthru_reg),
        .off_m2  (off - 4'd2),
        .clk_new (clk_next),
        .new_row (new_row),
        .res     (res),
        .cyc     (cyc)
    );

    // statistics
    logic [CW-1:0] ld_reg, st_reg, lh_reg, lm_reg, sh_reg, sm_reg;
    logic [CW-1:0] ld_next, st_next, lh_next, lm_next, sh_next, sm_next;
    logic [TW-1:0] tot_reg, tot_next;
    logic [TW:0]   tot_sum;

    function automatic logic [csc_pkg::CNT_W-1:0] sat_inc(
        input logic [csc_pkg::CNT_W-1:0] v, input logic en);
        sat_inc = (en && v != '1) ? v + 1'b1 : v;
    endfunction

    always_comb begin
        ld_next = sat_inc(ld_reg, !store_reg);
        st_next = sat_inc(st_reg, store_reg);
        lh_next = sat_inc(lh_reg, res.outcome == csc_pkg::OUT_LOAD_HIT);
        lm_next = sat_inc(lm_reg, res.outcome == csc_pkg::OUT_LOAD_MISS);
        sh_next = sat_inc(sh_reg, res.outcome == csc_pkg::OUT_STORE_HIT);
        sm_next = sat_inc(sm_reg, res.outcome == csc_pkg::OUT_STORE_MISS);
        tot_sum  = {1'b0, tot_reg} + (TW+1)'(cyc);
        tot_next = tot_sum[TW] ? '1 : tot_sum[TW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_reg <= '0;
            ld_reg  <= '0;
            st_reg  <= '0;
            lh_reg  <= '0;
            lm_reg  <= '0;
            sh_reg  <= '0;
            sm_reg  <= '0;
            tot_reg <= '0;
        end else if (commit) begin
            clk_reg <= clk_next;
            ld_reg  <= ld_next;
            st_reg  <= st_next;
            lh_reg  <= lh_next;
            lm_reg  <= lm_next;
            sh_reg  <= sh_next;
            sm_reg  <= sm_next;
            tot_reg <= tot_next;
        end
    end

    // result register
    logic m_valid_reg;
    logic [279:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_data_reg <= {2'b00, tot_next, sm_next, sh_next, lm_next, lh_next,
                           st_next, ld_next, res.wrote_back, res.filled,
                           cyc[csc_pkg::ACC_CYC_W-1:0], res.outcome};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
